### design/psu_pkg.sv
`default_nettype none
package psu_pkg;

    localparam int MAX_ROW_BYTES = 4096;
    localparam int MAX_ROWS      = 4096;

    // register port
    localparam int CFG_DW = 13;
    localparam int CFG_IW = 2;

    // row store and counters
    localparam int ROW_AW = $clog2(MAX_ROW_BYTES);    // row store address
    localparam int COL_W  = $clog2(MAX_ROW_BYTES + 1); // column, holds row length
    localparam int ROWC_W = $clog2(MAX_ROWS);          // row index

    typedef enum logic [CFG_IW-1:0] {
        REG_ROW_BYTES    = 2'd0,
        REG_PIXEL_FORMAT = 2'd1,
        REG_IMAGE_ROWS   = 2'd2,
        REG_UNUSED       = 2'd3
    } t_reg_idx;

    typedef enum logic [2:0] {
        FLT_NONE  = 3'd0,
        FLT_SUB   = 3'd1,
        FLT_UP    = 3'd2,
        FLT_AVG   = 3'd3,
        FLT_PAETH = 3'd4
    } t_filter;

    localparam logic [7:0] FLT_MAX_CODE = 8'd4;

    typedef enum logic [1:0] {
        K_ROWSTART = 2'd0,
        K_DATA     = 2'd1,
        K_BAD      = 2'd2
    } t_kind;

    // work item between the counter stage and the reconstruction stage
    typedef struct packed {
        t_kind               kind;
        logic [7:0]          data;
        logic [2:0]          filter;
        logic [ROW_AW-1:0]   x;
        logic                first_row;
        logic                last_col;
        logic                last_row;
    } t_stage;

    function automatic logic [7:0] paeth_pick(input logic [7:0] a, input logic [7:0] b,
                                              input logic [7:0] c);
        logic signed [10:0] pa_s;
        logic signed [10:0] pb_s;
        logic signed [10:0] pc_s;
        logic [10:0] pa;
        logic [10:0] pb;
        logic [10:0] pc;
        pa_s = $signed({3'b000, b}) - $signed({3'b000, c});
        pb_s = $signed({3'b000, a}) - $signed({3'b000, c});
        pc_s = pa_s + pb_s;
        pa = pa_s[10] ? 11'(-pa_s) : 11'(pa_s);
        pb = pb_s[10] ? 11'(-pb_s) : 11'(pb_s);
        pc = pc_s[10] ? 11'(-pc_s) : 11'(pc_s);
        if (pa <= pb && pa <= pc) begin
            return a;
        end else if (pb <= pc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

endpackage
`default_nettype wire

### design/png_scanline_unfilter_unit.sv
`default_nettype none
// PNG scanline reconstruction, 8-bit samples, one stream byte per beat.
// Input channel (i_in_valid / o_in_ready): the inflated stream. Each row is
// a filter-type byte followed by row_bytes filtered bytes.
// Output channel (o_out_valid / i_out_ready): one beat per data byte with
// the reconstructed pixel byte plus row_end / image_end marks; a filter
// byte above 4 gives one beat with bad_filter set, then the rest of that
// image is swallowed without output.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0
// row_bytes, 1 pixel_format (0 gray-alpha, 1 RGBA), 2 image_rows. Write
// only while the block is idle.
// Throughput: one byte per clock while the receiver is ready. Path: the
// reconstruction stage (row store read), then the output register.
// The previous row lives in a 4096 x 8 synchronous RAM: read at accept,
// written back when the byte leaves the reconstruction stage.
// Reset: counters cleared, expecting a filter byte; config back to
// row_bytes 4096, RGBA, one row. The row store is not cleared; the first
// row of an image never reads it.
// Receiver stall: the output register holds, the reconstruction stage
// holds, and o_in_ready drops once both are full.
module png_scanline_unfilter_unit (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_in_valid,
    output logic                         o_in_ready,
    input  wire  [7:0]                   i_filtered_byte,
    output logic                         o_out_valid,
    input  wire                          i_out_ready,
    output logic [7:0]                   o_pixel_byte,
    output logic                         o_bad_filter,
    output logic                         o_row_end,
    output logic                         o_image_end,
    input  wire                          i_cfg_valid,
    output logic                         o_cfg_ready,
    input  wire  [psu_pkg::CFG_IW-1:0]   i_cfg_index,
    input  wire  [psu_pkg::CFG_DW-1:0]   i_cfg_data
);
    import psu_pkg::*;

    // config
    logic [CFG_DW-1:0] r_row_bytes;
    logic              r_pixel_format;
    logic [CFG_DW-1:0] r_image_rows;

    // counter stage
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROWC_W-1:0] r_row, n_row;
    logic [2:0]        r_filter, n_filter;
    logic              r_drain, n_drain;

    // reconstruction stage
    logic              r_b_valid;
    t_stage            r_b, n_b;
    logic              n_b_load;
    logic [7:0]        r_up_raw;
    logic [7:0]        r_left [4];
    logic [7:0]        r_uleft [4];

    // output register
    logic              r_out_valid;
    logic [7:0]        r_pixel;
    logic              r_bad;
    logic              r_row_end;
    logic              r_img_end;

    // row store
    logic [7:0]        r_above [MAX_ROW_BYTES];

    logic [COL_W-1:0]  eff_rb;
    logic [CFG_DW-1:0] eff_rows;
    logic              in_fire;
    logic              out_free;
    logic              b_adv;
    logic              last_col;
    logic              last_row;
    logic [ROW_AW-1:0] rd_addr;
    logic [1:0]        tap;
    logic [7:0]        left_b, uleft_b, up_b, pred, val;
    logic [8:0]        avg_sum;

    assign o_cfg_ready = 1'b1;

    // clamp registers into their legal ranges
    always_comb begin
        if (r_row_bytes == '0) begin
            eff_rb = COL_W'(1);
        end else if (32'(r_row_bytes) > MAX_ROW_BYTES) begin
            eff_rb = COL_W'(MAX_ROW_BYTES);
        end else begin
            eff_rb = COL_W'(r_row_bytes);
        end
        if (r_image_rows == '0) begin
            eff_rows = CFG_DW'(1);
        end else if (32'(r_image_rows) > MAX_ROWS) begin
            eff_rows = CFG_DW'(MAX_ROWS);
        end else begin
            eff_rows = r_image_rows;
        end
    end

    // result-bearing items need the output register; row starts do not
    assign out_free   = !r_out_valid || i_out_ready;
    assign b_adv      = r_b_valid && (r_b.kind == K_ROWSTART || out_free);
    assign o_in_ready = !r_b_valid || b_adv;
    assign in_fire    = i_in_valid && o_in_ready;

    assign last_col = r_col >= eff_rb;
    assign last_row = (CFG_DW'(r_row) + CFG_DW'(1)) >= eff_rows;
    assign rd_addr  = ROW_AW'(r_col - COL_W'(1));

    // counter stage: row/column tracking, filter type check, drain
    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_filter = r_filter;
        n_drain  = r_drain;
        n_b_load = 1'b0;
        n_b.kind      = K_DATA;
        n_b.data      = i_filtered_byte;
        n_b.filter    = r_filter;
        n_b.x         = rd_addr;
        n_b.first_row = (r_row == '0);
        n_b.last_col  = last_col;
        n_b.last_row  = last_row;
        if (r_col == '0) begin
            n_col = COL_W'(1);
            if (!r_drain) begin
                n_b_load = 1'b1;
                if (i_filtered_byte > FLT_MAX_CODE) begin
                    n_drain  = 1'b1;
                    n_b.kind = K_BAD;
                end else begin
                    n_filter = i_filtered_byte[2:0];
                    n_b.kind = K_ROWSTART;
                end
            end
        end else begin
            n_b_load = !r_drain;
            if (last_col) begin
                n_col = '0;
                if (last_row) begin
                    n_row    = '0;
                    n_filter = FLT_NONE;
                    n_drain  = 1'b0;
                end else begin
                    n_row = r_row + ROWC_W'(1);
                end
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
    end

    // reconstruction: neighbours and predictor
    always_comb begin
        tap     = r_pixel_format ? 2'd3 : 2'd1;
        left_b  = r_left[tap];
        uleft_b = r_uleft[tap];
        up_b    = r_b.first_row ? 8'd0 : r_up_raw;
        avg_sum = {1'b0, left_b} + {1'b0, up_b};
        case (r_b.filter)
            FLT_SUB:   pred = left_b;
            FLT_UP:    pred = up_b;
            FLT_AVG:   pred = avg_sum[8:1];
            FLT_PAETH: pred = paeth_pick(left_b, up_b, uleft_b);
            default:   pred = 8'd0;
        endcase
        val = r_b.data + pred;
    end

    // row store: read at accept, write back when the byte retires
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_up_raw <= r_above[rd_addr];
        end
        if (b_adv && r_b.kind == K_DATA) begin
            r_above[r_b.x] <= val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && n_b_load) begin
            r_b <= n_b;
        end
        if (out_free && b_adv && r_b.kind != K_ROWSTART) begin
            r_pixel   <= (r_b.kind == K_DATA) ? val : 8'd0;
            r_bad     <= (r_b.kind == K_BAD);
            r_row_end <= (r_b.kind == K_DATA) && r_b.last_col;
            r_img_end <= (r_b.kind == K_DATA) && r_b.last_col && r_b.last_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes    <= CFG_DW'(MAX_ROW_BYTES);
            r_pixel_format <= 1'b1;
            r_image_rows   <= CFG_DW'(1);
            r_col          <= '0;
            r_row          <= '0;
            r_filter       <= FLT_NONE;
            r_drain        <= 1'b0;
            r_b_valid      <= 1'b0;
            r_out_valid    <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                r_left[i]  <= 8'd0;
                r_uleft[i] <= 8'd0;
            end
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_ROW_BYTES:    r_row_bytes    <= i_cfg_data;
                    REG_PIXEL_FORMAT: r_pixel_format <= i_cfg_data[0];
                    REG_IMAGE_ROWS:   r_image_rows   <= i_cfg_data;
                    default:          ;
                endcase
            end
            if (in_fire) begin
                r_col    <= n_col;
                r_row    <= n_row;
                r_filter <= n_filter;
                r_drain  <= n_drain;
            end
            if (in_fire && n_b_load) begin
                r_b_valid <= 1'b1;
            end else if (b_adv) begin
                r_b_valid <= 1'b0;
            end
            // left / above-left history, cleared at each row start
            if (b_adv) begin
                if (r_b.kind == K_DATA) begin
                    for (int i = 3; i > 0; i--) begin
                        r_left[i]  <= r_left[i-1];
                        r_uleft[i] <= r_uleft[i-1];
                    end
                    r_left[0]  <= val;
                    r_uleft[0] <= up_b;
                end else begin
                    for (int i = 0; i < 4; i++) begin
                        r_left[i]  <= 8'd0;
                        r_uleft[i] <= 8'd0;
                    end
                end
            end
            if (out_free && b_adv && r_b.kind != K_ROWSTART) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_byte = r_pixel;
    assign o_bad_filter = r_bad;
    assign o_row_end    = r_row_end;
    assign o_image_end  = r_img_end;

endmodule
`default_nettype wire

### dv/png_scanline_unfilter_unit_test.sv
`timescale 1ns / 100ps
module png_scanline_unfilter_unit_test;
    import psu_pkg::*;

    // quiet cycles before a register write; covers the two-stage pipe plus
    // any beat that produces no output (filter bytes, drained bytes)
    localparam int SETTLE_CYCLES = 8;
    // random input beats per idling phase
    localparam int PHASE_BEATS = 170;

    typedef struct packed {
        logic [7:0] pixel;
        logic       bad_filter;
        logic       row_end;
        logic       image_end;
    } t_pixel_beat;

    // Scoreboard: rebuilds every scanline byte on its own copy of the row
    // store and neighbor history, queues the expected output beats and
    // checks each output beat against the oldest one.
    class t_scanline_scoreboard;
        logic [7:0]        prev_row [MAX_ROW_BYTES];
        logic [7:0]        left_hist [4];
        logic [7:0]        up_left_hist [4];
        int unsigned       column;
        int unsigned       row;
        t_filter           row_filter;
        bit                draining;
        logic [CFG_DW-1:0] cfg_row_bytes;
        logic              cfg_rgba;
        logic [CFG_DW-1:0] cfg_image_rows;
        t_pixel_beat       expected_pixels [$];
        int unsigned       errors;

        function new();
            foreach (prev_row[i]) prev_row[i] = 8'h00;
            cfg_row_bytes  = 13'd4096;
            cfg_rgba       = 1'b1;
            cfg_image_rows = 13'd1;
            errors         = 0;
            restart_image();
        endfunction

        function void clear_history();
            foreach (left_hist[i]) begin
                left_hist[i]    = 8'h00;
                up_left_hist[i] = 8'h00;
            end
        endfunction

        function void restart_image();
            column     = 0;
            row        = 0;
            row_filter = FLT_NONE;
            draining   = 1'b0;
            clear_history();
        endfunction

        // out-of-range lengths clamp into 1..MAX
        function int unsigned row_length();
            if (cfg_row_bytes == 0) return 1;
            if (cfg_row_bytes > MAX_ROW_BYTES) return MAX_ROW_BYTES;
            return cfg_row_bytes;
        endfunction

        function int unsigned image_length();
            if (cfg_image_rows == 0) return 1;
            if (cfg_image_rows > MAX_ROWS) return MAX_ROWS;
            return cfg_image_rows;
        endfunction

        function bit at_image_start();
            return column == 0 && row == 0;
        endfunction

        function int unsigned pending();
            return expected_pixels.size();
        endfunction

        // appends one expected beat at the tail of the queue
        function void expect_beat(t_pixel_beat item);
            expected_pixels = {expected_pixels, item};
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_DW-1:0] data);
            case (idx)
                REG_ROW_BYTES:    cfg_row_bytes  = data;
                REG_PIXEL_FORMAT: cfg_rgba       = data[0];
                REG_IMAGE_ROWS:   cfg_image_rows = data;
                default: ;
            endcase
        endfunction

        function logic [7:0] paeth(logic [7:0] a, logic [7:0] b, logic [7:0] c);
            int ia;
            int ib;
            int ic;
            int p;
            int da;
            int db;
            int dc;
            ia = a;
            ib = b;
            ic = c;
            p  = ia + ib - ic;
            da = (p > ia) ? p - ia : ia - p;
            db = (p > ib) ? p - ib : ib - p;
            dc = (p > ic) ? p - ic : ic - p;
            if (da <= db && da <= dc) return a;
            if (db <= dc) return b;
            return c;
        endfunction

        // one accepted stream byte -> zero or one expected output beat
        function void note_stream_byte(logic [7:0] b);
            int unsigned x;
            int unsigned bpp;
            bit          last_col;
            bit          last_row;
            logic [7:0]  left;
            logic [7:0]  up;
            logic [7:0]  up_left;
            logic [7:0]  pred;
            logic [7:0]  value;
            if (column == 0) begin
                // filter-type byte
                column = 1;
                clear_history();
                if (draining) return;
                if (b > FLT_MAX_CODE) begin
                    draining = 1'b1;
                    expect_beat('{pixel: 8'h00, bad_filter: 1'b1,
                                  row_end: 1'b0, image_end: 1'b0});
                    return;
                end
                row_filter = t_filter'(b[2:0]);
                return;
            end
            x        = column - 1;
            last_col = (x + 1 >= row_length());
            last_row = (row + 1 >= image_length());
            if (!draining) begin
                bpp     = cfg_rgba ? 4 : 2;
                left    = left_hist[bpp-1];
                up_left = up_left_hist[bpp-1];
                up      = (row != 0 && x < MAX_ROW_BYTES) ? prev_row[x] : 8'h00;
                case (row_filter)
                    FLT_SUB:   pred = left;
                    FLT_UP:    pred = up;
                    FLT_AVG:   pred = 8'((int'(left) + int'(up)) >> 1);
                    FLT_PAETH: pred = paeth(left, up, up_left);
                    default:   pred = 8'h00;
                endcase
                value = b + pred;
                if (x < MAX_ROW_BYTES) prev_row[x] = value;
                for (int i = 3; i > 0; i--) begin
                    left_hist[i]    = left_hist[i-1];
                    up_left_hist[i] = up_left_hist[i-1];
                end
                left_hist[0]    = value;
                up_left_hist[0] = up;
                expect_beat('{pixel: value, bad_filter: 1'b0,
                              row_end: last_col,
                              image_end: last_col && last_row});
            end
            if (last_col) begin
                if (last_row) begin
                    restart_image();
                end else begin
                    column = 0;
                    row++;
                end
            end else begin
                column++;
            end
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_pixel_beat(logic [7:0] pixel, logic bad, logic re, logic ie);
            t_pixel_beat want;
            if (expected_pixels.size() == 0) begin
                errors++;
                $display("%0t: output beat with nothing expected, %s %0h/%0b/%0b/%0b",
                         $time, "expected none, actual", pixel, bad, re, ie);
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("pixel_byte", want.pixel, pixel);
            compare_field("bad_filter", 8'(want.bad_filter), 8'(bad));
            compare_field("row_end", 8'(want.row_end), 8'(re));
            compare_field("image_end", 8'(want.image_end), 8'(ie));
        endfunction
    endclass

    logic              i_clk           = 1'b0;
    logic              i_rst_n         = 1'b0;
    logic              i_in_valid      = 1'b0;
    logic [7:0]        i_filtered_byte = 8'h00;
    logic              i_out_ready     = 1'b0;
    logic              i_cfg_valid     = 1'b0;
    logic [CFG_IW-1:0] i_cfg_index     = REG_ROW_BYTES;
    logic [CFG_DW-1:0] i_cfg_data      = '0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [7:0]        o_pixel_byte;
    logic              o_bad_filter;
    logic              o_row_end;
    logic              o_image_end;
    logic              o_cfg_ready;

    t_scanline_scoreboard sb;
    int unsigned send_idle_pct     = 0;
    int unsigned recv_idle_pct     = 0;
    int unsigned ready_hold_cycles = 0;  // long receiver hold-off, counted down below
    int unsigned beats_sent        = 0;

    png_scanline_unfilter_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_filtered_byte (i_filtered_byte),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_pixel_byte    (o_pixel_byte),
        .o_bad_filter    (o_bad_filter),
        .o_row_end       (o_row_end),
        .o_image_end     (o_image_end),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: checks every output beat taken at this edge, then picks
    // ready for the next cycle. A pending hold-off keeps ready low for its
    // whole length so the pipe backs up into the input channel.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                sb.check_pixel_beat(o_pixel_byte, o_bad_filter, o_row_end, o_image_end);
            end
            if (ready_hold_cycles != 0) begin
                ready_hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // One input beat. Returns at the accepting edge with valid still high,
    // so a back-to-back beat only swaps the payload.
    task automatic push_byte(input logic [7:0] b);
        if ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_in_valid      <= 1'b1;
        i_filtered_byte <= b;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_stream_byte(b);
        beats_sent++;
    endtask

    // Sender pause: no new beats until every expected beat has come out.
    task automatic wait_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() != 0);
    endtask

    // Block idle: drained, plus slack for beats that give no output.
    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // valid dropped for one cycle after each write so that back-to-back
    // writes never assign valid twice in one step
    task automatic write_reg(input t_reg_idx idx, input logic [CFG_DW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // filter byte then one row of data; boundary mode draws from values that
    // hit the wrap and Paeth tie cases
    task automatic send_row(input logic [7:0] filter_code, input bit boundary);
        int unsigned n;
        logic [7:0]  data;
        n = sb.row_length();
        push_byte(filter_code);
        repeat (n) begin
            if (boundary) begin
                case ($urandom_range(5))
                    0: data = 8'h00;
                    1: data = 8'h01;
                    2: data = 8'h7F;
                    3: data = 8'h80;
                    4: data = 8'hFE;
                    default: data = 8'hFF;
                endcase
            end else begin
                data = 8'($urandom_range(255));
            end
            if ($urandom_range(199) == 0) wait_results();
            push_byte(data);
        end
    endtask

    // whole image at the current settings; mostly legal filters, a few bad
    // ones, and anything at all once the image is being drained
    task automatic send_image();
        logic [7:0] code;
        do begin
            if (sb.draining) begin
                code = 8'($urandom_range(255));
            end else if ($urandom_range(99) < 4) begin
                code = 8'($urandom_range(255, 5));
            end else begin
                code = 8'($urandom_range(4));
            end
            send_row(code, $urandom_range(9) < 3);
        end while (!sb.at_image_start());
    endtask

    task automatic random_image();
        int unsigned pick;
        logic [CFG_DW-1:0] len;
        settle();
        if ($urandom_range(1)) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                len = CFG_DW'($urandom_range(1));
            end else if (pick < 85) begin
                len = CFG_DW'($urandom_range(16, 2));
            end else begin
                len = CFG_DW'($urandom_range(96, 17));
            end
            write_reg(REG_ROW_BYTES, len);
        end
        if ($urandom_range(1)) write_reg(REG_PIXEL_FORMAT, CFG_DW'($urandom_range(8191)));
        if ($urandom_range(1)) write_reg(REG_IMAGE_ROWS, CFG_DW'($urandom_range(5)));
        if ($urandom_range(9) == 0) write_reg(REG_UNUSED, CFG_DW'($urandom));
        send_image();
    endtask

    task automatic random_phase();
        int unsigned start;
        start = beats_sent;
        while (beats_sent - start < PHASE_BEATS) random_image();
    endtask

    initial begin
        sb = new();
        send_idle_pct = 38;
        recv_idle_pct = 65;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // --- directed ---
        // pixel format and row count still at reset: RGBA, one row, so a
        // sub filter sees only zero on the left
        write_reg(REG_ROW_BYTES, 13'd2);
        push_byte(8'(FLT_SUB));
        push_byte(8'hFF);
        push_byte(8'h01);

        // gray-alpha, five rows of three: one row per filter type, the up,
        // average and Paeth rows reading the row above
        settle();
        write_reg(REG_PIXEL_FORMAT, 13'd0);
        write_reg(REG_ROW_BYTES, 13'd3);
        write_reg(REG_IMAGE_ROWS, 13'd5);
        for (int f = 0; f <= 4; f++) begin
            push_byte(8'(f));
            push_byte(8'hFF);
            push_byte(8'h00);
            push_byte(8'h7F + 8'(f));
        end

        // smallest bad filter code: one error beat, the data byte is drained
        settle();
        write_reg(REG_ROW_BYTES, 13'd1);
        write_reg(REG_IMAGE_ROWS, 13'd1);
        push_byte(8'd5);
        push_byte(8'hA5);

        // largest bad code in the first of two rows: the second row's filter
        // byte is swallowed along with the data
        settle();
        write_reg(REG_IMAGE_ROWS, 13'd2);
        push_byte(8'hFF);
        push_byte(8'h3C);
        push_byte(8'(FLT_UP));
        push_byte(8'hC3);

        // zero lengths clamp to one; the spare index must be harmless
        settle();
        write_reg(REG_ROW_BYTES, 13'd0);
        write_reg(REG_IMAGE_ROWS, 13'd0);
        write_reg(REG_UNUSED, 13'h1FFF);
        push_byte(8'(FLT_PAETH));
        push_byte(8'h80);

        // settings changed between rows of one image: shorter rows, other
        // pixel format, and a row total the current row already passes
        settle();
        write_reg(REG_ROW_BYTES, 13'd6);
        write_reg(REG_PIXEL_FORMAT, 13'd1);
        write_reg(REG_IMAGE_ROWS, 13'd4);
        send_row(8'(FLT_PAETH), 1'b0);
        send_row(8'(FLT_UP), 1'b1);
        settle();
        write_reg(REG_ROW_BYTES, 13'd3);
        write_reg(REG_PIXEL_FORMAT, 13'd0);
        write_reg(REG_IMAGE_ROWS, 13'd2);
        send_row(8'(FLT_AVG), 1'b0);

        // --- random, sender 38 / receiver 65 ---
        random_phase();

        // --- random, sender 65 / receiver 38 ---
        send_idle_pct = 65;
        recv_idle_pct = 38;
        random_phase();

        // --- no idling ---
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // receiver holds off for a long stretch while the sender keeps
        // offering beats; the pipe fills and input ready must drop
        settle();
        write_reg(REG_ROW_BYTES, 13'd32);
        write_reg(REG_PIXEL_FORMAT, 13'd1);
        write_reg(REG_IMAGE_ROWS, 13'd3);
        ready_hold_cycles = 300;
        send_image();

        random_phase();

        wait_results();
        repeat (SETTLE_CYCLES * 2) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #4_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
